// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the AES block cipher.
// No dependencies; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hw/rtl/aesbcm_pkg.sv =====
// Types, constants and round functions for the AES block cipher.
// No dependencies; used by every module of the block.
package aesbcm_pkg;

  localparam logic [2:0] OP_ECB_ENC = 3'd0;
  localparam logic [2:0] OP_ECB_DEC = 3'd1;
  localparam logic [2:0] OP_CBC_ENC = 3'd2;
  localparam logic [2:0] OP_CBC_DEC = 3'd3;
  localparam logic [2:0] OP_CFB_ENC = 3'd4;
  localparam logic [2:0] OP_CFB_DEC = 3'd5;

  localparam logic [2:0] REG_KEY_SIZE  = 3'd0;
  localparam logic [2:0] REG_OPERATION = 3'd1;
  localparam logic [2:0] REG_KEY_0     = 3'd2;
  localparam logic [2:0] REG_KEY_1     = 3'd3;
  localparam logic [2:0] REG_KEY_2     = 3'd4;
  localparam logic [2:0] REG_KEY_3     = 3'd5;
  localparam logic [2:0] REG_IV_HIGH   = 3'd6;
  localparam logic [2:0] REG_IV_LOW    = 3'd7;

  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXPAND, ST_RDC0, ST_RDC1, ST_PREP, ST_ROUND, ST_OUT, ST_WB0, ST_WB1
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic dec;
    logic add_only;
    logic mix;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } kx_status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RSBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [3:0] nr_of(input logic [1:0] ks);
    logic [3:0] n;
    unique case (ks)
      KS_128:  n = 4'd10;
      KS_192:  n = 4'd12;
      default: n = 4'd14;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] a);
    logic [7:0] a0, a1, a2, a3;
    a0 = a[31:24];
    a1 = a[23:16];
    a2 = a[15:8];
    a3 = a[7:0];
    return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
            xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] a);
    logic [7:0] x [4];
    logic [7:0] m9 [4], m11 [4], m13 [4], m14 [4];
    logic [7:0] d2, d4, d8;
    for (int i = 0; i < 4; i++) begin
      x[i] = a[31 - 8 * i -: 8];
      d2 = xt(x[i]);
      d4 = xt(d2);
      d8 = xt(d4);
      m9[i] = d8 ^ x[i];
      m11[i] = d8 ^ d2 ^ x[i];
      m13[i] = d8 ^ d4 ^ x[i];
      m14[i] = d8 ^ d4 ^ d2;
    end
    return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
            m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
            m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
            m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic mix);
    logic [7:0] b [16];
    logic [127:0] t;
    for (int k = 0; k < 16; k++) b[k] = s[127 - 8 * k -: 8];
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < 4; k++)
        t[127 - 8 * (c * 4 + k) -: 8] = SBOX[b[((c + k) % 4) * 4 + k]];
    if (mix) begin
      for (int c = 0; c < 4; c++) t[127 - 32 * c -: 32] = mix_col(t[127 - 32 * c -: 32]);
    end
    return t ^ rk;
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic mix);
    logic [7:0] b [16];
    logic [127:0] t;
    for (int k = 0; k < 16; k++) b[k] = s[127 - 8 * k -: 8];
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < 4; k++)
        t[127 - 8 * (c * 4 + k) -: 8] = RSBOX[b[((c - k + 4) % 4) * 4 + k]];
    t = t ^ rk;
    if (mix) begin
      for (int c = 0; c < 4; c++) t[127 - 32 * c -: 32] = inv_mix_col(t[127 - 32 * c -: 32]);
    end
    return t;
  endfunction

endpackage

// ===== hw/rtl/aesbcm_key_exp.sv =====
// Key schedule unit: expands the key one round key per cycle into the round key memory.
// Depends on aesbcm_pkg for the S-box and the key size decode.
module aesbcm_key_exp
  import aesbcm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [255:0] key,
  input  logic [1:0]   key_size,
  input  logic [3:0]   raddr,
  output logic [127:0] rdata,
  output kx_status_t   status
);

  logic [127:0] key_mem_r [15];
  logic [127:0] rdata_r;
  logic [31:0]  hist_r [1:8];
  logic         busy_r;
  logic [3:0]   row_r;
  logic [2:0]   pos_r;
  logic [7:0]   rc_r;

  logic [3:0]  nr;
  logic [3:0]  nk;
  logic [31:0] lane [4];
  logic        rc_used;
  logic [3:0]  pos_sum;
  logic [3:0]  pos_adv;

  assign nr = nr_of(key_size);
  assign nk = nr - 4'd6;
  assign status.busy = busy_r;
  assign status.done = busy_r && (row_r == nr);
  assign rdata = rdata_r;

  always_comb begin
    logic [31:0] prev, back, t;
    logic [5:0]  idx;
    logic [3:0]  pj;
    rc_used = 1'b0;
    for (int j = 0; j < 4; j++) begin
      idx = {row_r, 2'b00} + 6'(j);
      pj = {1'b0, pos_r} + 4'(j);
      if (pj >= nk) pj = pj - nk;
      prev = (j == 0) ? hist_r[1] : lane[(j == 0) ? 0 : j - 1];
      priority if (nk == 4'd4) back = hist_r[4 - j];
      else if (nk == 4'd6) back = hist_r[6 - j];
      else back = hist_r[8 - j];
      t = prev;
      if (pj == 4'd0) begin
        t = {SBOX[prev[23:16]] ^ rc_r, SBOX[prev[15:8]], SBOX[prev[7:0]], SBOX[prev[31:24]]};
      end else if (nk == 4'd8 && pj == 4'd4) begin
        t = {SBOX[prev[31:24]], SBOX[prev[23:16]], SBOX[prev[15:8]], SBOX[prev[7:0]]};
      end
      if ({2'b00, idx} < {4'b0000, nk}) begin
        lane[j] = (row_r == 4'd0) ? key[255 - 32 * j -: 32] : key[127 - 32 * j -: 32];
      end else begin
        lane[j] = back ^ t;
        if (pj == 4'd0) rc_used = 1'b1;
      end
    end
    pos_sum = {1'b0, pos_r} + 4'd4;
    pos_adv = (pos_sum >= nk) ? pos_sum - nk : pos_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r <= 4'd0;
      pos_r <= 3'd0;
      rc_r <= 8'h01;
    end else if (start) begin
      busy_r <= 1'b1;
      row_r <= 4'd0;
      pos_r <= 3'd0;
      rc_r <= 8'h01;
    end else if (busy_r) begin
      row_r <= row_r + 4'd1;
      pos_r <= pos_adv[2:0];
      if (rc_used) rc_r <= xt(rc_r);
      if (row_r == nr) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      key_mem_r[row_r] <= {lane[0], lane[1], lane[2], lane[3]};
      hist_r[1] <= lane[3];
      hist_r[2] <= lane[2];
      hist_r[3] <= lane[1];
      hist_r[4] <= lane[0];
      hist_r[5] <= hist_r[1];
      hist_r[6] <= hist_r[2];
      hist_r[7] <= hist_r[3];
      hist_r[8] <= hist_r[4];
    end
    rdata_r <= key_mem_r[raddr];
  end

endmodule

// ===== hw/rtl/aesbcm_round.sv =====
// Round datapath: holds the cipher state and applies one AES round per step.
// Depends on aesbcm_pkg for the round functions and the control struct.
module aesbcm_round
  import aesbcm_pkg::*;
(
  input  logic         clk,
  input  core_ctl_t    ctl,
  input  logic [127:0] load_data,
  input  logic [127:0] round_key,
  output logic [127:0] state
);

  logic [127:0] s_r;

  assign state = s_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      s_r <= load_data;
    end else if (ctl.step) begin
      if (ctl.add_only) s_r <= s_r ^ round_key;
      else if (ctl.dec) s_r <= dec_round(s_r, round_key, ctl.mix);
      else s_r <= enc_round(s_r, round_key, ctl.mix);
    end
  end

endmodule

// ===== hw/rtl/aes_block_cipher_modes.sv =====
// Top level of the AES block cipher with ECB, CBC and CFB-128 modes.
// Depends on aesbcm_pkg, aesbcm_key_exp, aesbcm_round and assert_macros.svh.
//
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   in_block_high, in_block_low, in_last_block
// out_     output     out_valid/out_stall out_result_high, out_result_low, out_result_last
// cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A result is ready in ST_OUT after its block passes ST_RDC0, ST_RDC1, ST_PREP and ST_ROUND, one round per cycle.
// A new block is taken only in ST_IDLE, after the last one has left ST_OUT and any chain write-back.
// The first block after reset or a key or key size write waits in ST_EXPAND for the key schedule.
// The chaining value lives in a two-entry memory, read and written back one half per cycle.
// Reset is synchronous; the chaining value reads as zero until first written.
// A stalled output holds the finished block; the next block is taken meanwhile.
`include "assert_macros.svh"
module aes_block_cipher_modes
  import aesbcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic        in_last_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low,
  output logic        out_result_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [1:0]   key_size_r;
  logic [2:0]   operation_r;
  logic [255:0] key_r;
  logic [63:0]  iv_hi_r, iv_lo_r;
  logic         keys_ok_r;

  logic [127:0] blk_r;
  logic         last_r;
  logic [63:0]  chain_hi_r;
  logic [127:0] chain_r;
  logic [3:0]   rnd_r;
  logic [127:0] wb_r;
  logic         out_valid_r;
  logic [63:0]  out_hi_r, out_lo_r;
  logic         out_last_r;

  logic [63:0]  chain_mem_r [2];
  logic [1:0]   chain_vld_r;
  logic [63:0]  chain_q_r;
  logic         chain_qv_r;
  logic [63:0]  chain_rd;
  logic         cm_we, cm_waddr, cm_raddr;
  logic [63:0]  cm_wdata;

  logic         in_xfer, cfg_xfer, out_free, key_wr;
  logic         is_dec, kx_start, out_load;
  logic [3:0]   nr, knext, key_raddr;
  logic [127:0] round_key, core_state, core_in, result, chain_new;
  logic         need_wb;
  core_ctl_t    core_ctl;
  kx_status_t   kx_status;

  assign in_stall = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_xfer = in_valid && !in_stall;
  assign cfg_xfer = cfg_valid && cfg_ready;
  assign key_wr = cfg_xfer && (cfg_index != REG_OPERATION) && (cfg_index != REG_IV_HIGH)
                  && (cfg_index != REG_IV_LOW);
  assign out_free = !out_valid_r || !out_stall;
  assign is_dec = (operation_r == OP_ECB_DEC) || (operation_r == OP_CBC_DEC);
  assign nr = nr_of(key_size_r);
  assign knext = rnd_r + 4'd1;
  assign chain_rd = chain_qv_r ? chain_q_r : 64'd0;
  assign out_valid = out_valid_r;
  assign out_result_high = out_hi_r;
  assign out_result_low = out_lo_r;
  assign out_result_last = out_last_r;

  aesbcm_key_exp u_key_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (kx_start),
    .key      (key_r),
    .key_size (key_size_r),
    .raddr    (key_raddr),
    .rdata    (round_key),
    .status   (kx_status)
  );

  aesbcm_round u_round (
    .clk       (clk),
    .ctl       (core_ctl),
    .load_data (core_in),
    .round_key (round_key),
    .state     (core_state)
  );

  always_comb begin
    priority case (operation_r)
      OP_CBC_ENC:             core_in = blk_r ^ {chain_hi_r, chain_rd};
      OP_CFB_ENC, OP_CFB_DEC: core_in = {chain_hi_r, chain_rd};
      default:                core_in = blk_r;
    endcase
    result = core_state;
    chain_new = chain_r;
    need_wb = 1'b1;
    priority case (operation_r)
      OP_CBC_ENC: chain_new = core_state;
      OP_CBC_DEC: begin
        result = core_state ^ chain_r;
        chain_new = blk_r;
      end
      OP_CFB_ENC: begin
        result = core_state ^ blk_r;
        chain_new = core_state ^ blk_r;
      end
      OP_CFB_DEC: begin
        result = core_state ^ blk_r;
        chain_new = blk_r;
      end
      default: need_wb = 1'b0;
    endcase
    if (last_r) begin
      chain_new = {iv_hi_r, iv_lo_r};
      need_wb = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    kx_start = 1'b0;
    core_ctl = '0;
    core_ctl.dec = is_dec;
    core_ctl.add_only = (rnd_r == 4'd0);
    core_ctl.mix = (rnd_r != nr);
    key_raddr = 4'd0;
    cm_raddr = 1'b0;
    cm_we = 1'b0;
    cm_waddr = 1'b0;
    cm_wdata = cfg_data;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_xfer && (cfg_index == REG_IV_HIGH || cfg_index == REG_IV_LOW)) begin
          cm_we = 1'b1;
          cm_waddr = (cfg_index == REG_IV_LOW);
        end
        if (in_xfer) begin
          kx_start = !keys_ok_r || key_wr;
          state_nxt = (!keys_ok_r || key_wr) ? ST_EXPAND : ST_RDC0;
        end
      end
      ST_EXPAND: if (kx_status.done) state_nxt = ST_RDC0;
      ST_RDC0: state_nxt = ST_RDC1;
      ST_RDC1: begin
        cm_raddr = 1'b1;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        core_ctl.load = 1'b1;
        key_raddr = is_dec ? nr : 4'd0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        core_ctl.step = 1'b1;
        if (rnd_r != nr) key_raddr = is_dec ? nr - knext : knext;
        if (rnd_r == nr) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_nxt = need_wb ? ST_WB0 : ST_IDLE;
        end
      end
      ST_WB0: begin
        cm_we = 1'b1;
        cm_wdata = wb_r[127:64];
        state_nxt = ST_WB1;
      end
      ST_WB1: begin
        cm_we = 1'b1;
        cm_waddr = 1'b1;
        cm_wdata = wb_r[63:0];
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_size_r <= 2'd2;
      operation_r <= OP_ECB_ENC;
      key_r <= '0;
      iv_hi_r <= '0;
      iv_lo_r <= '0;
      keys_ok_r <= 1'b0;
    end else begin
      if (state_r == ST_EXPAND && kx_status.done) keys_ok_r <= 1'b1;
      if (cfg_xfer) begin
        unique case (cfg_index)
          REG_KEY_SIZE: begin
            key_size_r <= cfg_data[1:0];
            keys_ok_r <= 1'b0;
          end
          REG_OPERATION: operation_r <= cfg_data[2:0];
          REG_KEY_0: begin
            key_r[255:192] <= cfg_data;
            keys_ok_r <= 1'b0;
          end
          REG_KEY_1: begin
            key_r[191:128] <= cfg_data;
            keys_ok_r <= 1'b0;
          end
          REG_KEY_2: begin
            key_r[127:64] <= cfg_data;
            keys_ok_r <= 1'b0;
          end
          REG_KEY_3: begin
            key_r[63:0] <= cfg_data;
            keys_ok_r <= 1'b0;
          end
          REG_IV_HIGH: iv_hi_r <= cfg_data;
          REG_IV_LOW: iv_lo_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rnd_r <= 4'd0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == ST_PREP) rnd_r <= 4'd0;
      else if (state_r == ST_ROUND) rnd_r <= knext;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      blk_r <= {in_block_high, in_block_low};
      last_r <= in_last_block;
    end
    if (state_r == ST_RDC1) chain_hi_r <= chain_rd;
    if (state_r == ST_PREP) chain_r <= {chain_hi_r, chain_rd};
    if (out_load) begin
      out_hi_r <= result[127:64];
      out_lo_r <= result[63:0];
      out_last_r <= last_r;
      wb_r <= chain_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cm_we) chain_mem_r[cm_waddr] <= cm_wdata;
    chain_q_r <= chain_mem_r[cm_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_vld_r <= 2'b00;
      chain_qv_r <= 1'b0;
    end else begin
      if (cm_we) chain_vld_r[cm_waddr] <= 1'b1;
      chain_qv_r <= chain_vld_r[cm_raddr];
    end
  end

  `ASSERT_RST(a_accept_starts, in_valid && !in_stall |=> state_r == ST_EXPAND || state_r == ST_RDC0)
  `ASSERT_RST(a_round_bound, state_r == ST_ROUND |-> rnd_r <= nr)
  `ASSERT_RST(a_out_from_final, $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
  `ASSERT_RST(a_keys_ready, state_r == ST_RDC0 |-> keys_ok_r)

endmodule
